@@ design/rwc_pkg.sv @@
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared types and constants of the replay window check: field widths and
// verdict codes.
// ----------------------------------------------------------------------------
package rwc_pkg;

	localparam int SEQ_W     = 64;
	localparam int VERDICT_W = 2;

	typedef logic [SEQ_W-1:0]     seq_t;
	typedef logic [VERDICT_W-1:0] verdict_t;

	localparam verdict_t VERDICT_OK    = 2'd0;
	localparam verdict_t VERDICT_AHEAD = 2'd1;
	localparam verdict_t VERDICT_OLD   = 2'd2;
	localparam verdict_t VERDICT_DUP   = 2'd3;

	typedef struct packed {
		logic     accept;
		verdict_t verdict;
	} result_t;

endpackage

@@ design/rwc_seq_if.sv @@
// ----------------------------------------------------------------------------
// rwc_seq_if
// Valid/ready channel carrying one received sequence number per transfer.
// ----------------------------------------------------------------------------
interface rwc_seq_if;
	logic          valid;
	logic          ready;
	rwc_pkg::seq_t received_sequence;

	modport source (output valid, output received_sequence, input ready);
	modport sink   (input valid, input received_sequence, output ready);
endinterface

@@ design/rwc_result_if.sv @@
// ----------------------------------------------------------------------------
// rwc_result_if
// Valid/ready channel carrying one accept flag and verdict per transfer.
// ----------------------------------------------------------------------------
interface rwc_result_if;
	logic              valid;
	logic              ready;
	logic              accept;
	rwc_pkg::verdict_t verdict;

	modport source (output valid, output accept, output verdict, input ready);
	modport sink   (input valid, input accept, input verdict, output ready);
endinterface

@@ design/rwc_eval.sv @@
// ----------------------------------------------------------------------------
// rwc_eval
// Window evaluation: classifies one sequence number against the expected
// number and seen map, and forms the next window state.
// ----------------------------------------------------------------------------
module rwc_eval #(
	parameter int WINDOW = 64
) (
	input  rwc_pkg::seq_t     rx,
	input  rwc_pkg::seq_t     expected,
	input  logic [WINDOW-1:0] map,
	output rwc_pkg::seq_t     expected_nxt,
	output logic [WINDOW-1:0] map_nxt,
	output rwc_pkg::result_t  result
);

	localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [rwc_pkg::SEQ_W:0]   diff;
	logic                      ahead;
	rwc_pkg::seq_t             gap;
	rwc_pkg::seq_t             dist_m1;
	logic [SW-1:0]             gap_idx;
	logic [SW-1:0]             bit_idx;
	logic [WINDOW:0]           shifted;
	logic [WINDOW-1:0]         bit_mask;

	assign diff    = {1'b0, rx} - {1'b0, expected};
	assign ahead   = !diff[rwc_pkg::SEQ_W];
	assign gap     = diff[rwc_pkg::SEQ_W-1:0];
	assign dist_m1 = expected + ~rx;
	assign gap_idx = gap[SW-1:0];
	assign bit_idx = dist_m1[SW-1:0];
	assign shifted = {map, 1'b0} << gap_idx;
	assign bit_mask = WINDOW'(1) << bit_idx;

	always_comb begin
		expected_nxt   = expected;
		map_nxt        = map;
		result.accept  = 1'b0;
		result.verdict = rwc_pkg::VERDICT_OK;
		if (ahead) begin
			if (gap >= rwc_pkg::seq_t'(WINDOW)) begin
				result.verdict = rwc_pkg::VERDICT_AHEAD;
			end else begin
				map_nxt       = shifted[WINDOW-1:0] | WINDOW'(1);
				expected_nxt  = rx + rwc_pkg::seq_t'(1);
				result.accept = 1'b1;
			end
		end else if (dist_m1 >= rwc_pkg::seq_t'(WINDOW)) begin
			result.verdict = rwc_pkg::VERDICT_OLD;
		end else if ((map & bit_mask) != '0) begin
			result.verdict = rwc_pkg::VERDICT_DUP;
		end else begin
			map_nxt       = map | bit_mask;
			result.accept = 1'b1;
		end
	end

endmodule

@@ design/replay_window_check_core.sv @@
// ----------------------------------------------------------------------------
// replay_window_check_core
// Anti-replay sliding window filter over 64-bit sequence numbers.
// Pipeline: input register, evaluation, result register; the evaluation is
//   combinational between the two registers.
// Throughput: one sequence number per cycle while the result side is not
//   stalled; the window state updates as an item leaves the input register.
// Reset: arst_n clears the expected number, the seen map and all valid flags.
// ----------------------------------------------------------------------------
module replay_window_check_core #(
	parameter int WINDOW = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	rwc_seq_if.sink        seq,
	rwc_result_if.source   res
);

	logic                     valid_s1;
	rwc_pkg::seq_t            rx_s1;
	logic                     valid_s2;
	rwc_pkg::result_t         result_s2;

	rwc_pkg::seq_t            expected_q;
	logic [WINDOW-1:0]        map_q;

	rwc_pkg::seq_t            expected_nxt;
	logic [WINDOW-1:0]        map_nxt;
	rwc_pkg::result_t         result;
	logic                     advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign seq.ready = !valid_s1 || advance;

	rwc_eval #(
		.WINDOW (WINDOW)
	) u_eval (
		.rx           (rx_s1),
		.expected     (expected_q),
		.map          (map_q),
		.expected_nxt (expected_nxt),
		.map_nxt      (map_nxt),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seq.ready) begin
			valid_s1 <= seq.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq.valid && seq.ready) begin
			rx_s1 <= seq.received_sequence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			map_q      <= '0;
		end else if (advance) begin
			expected_q <= expected_nxt;
			map_q      <= map_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign res.valid   = valid_s2;
	assign res.accept  = result_s2.accept;
	assign res.verdict = result_s2.verdict;

endmodule

@@ verif/tb_replay_window_check_core.sv @@
// ----------------------------------------------------------------------------
// tb_replay_window_check_core
// Self-checking bench for the anti-replay window filter. A short stimulus
// table covers exact matches, the largest jump, window edges, stale and
// duplicate numbers; random traffic follows, mostly near the expected number
// with some far-off noise. Both channels idle at random, and the result side
// holds off once for a long stretch. Each result is compared against a
// fixed table verdict or a behavioral window model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_replay_window_check_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW       = 64;
	localparam int POS_W        = $clog2(WINDOW);
	localparam int RANDOM_ITEMS = 1350;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;

	typedef struct {
		rwc_pkg::seq_t     num;
		bit                fixed;
		rwc_pkg::verdict_t verdict;
	} plan_row_t;

	logic clk;
	logic arst_n;

	rwc_seq_if    seq_ch ();
	rwc_result_if res_ch ();

	replay_window_check_core #(.WINDOW(WINDOW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.seq    (seq_ch),
		.res    (res_ch)
	);

	rwc_pkg::seq_t     win_next;
	logic [WINDOW-1:0] seen_bits;
	rwc_pkg::result_t  pending_verdicts[$];
	plan_row_t         plan[$];
	int                mismatch_count;
	int                idle_cycles;
	int                sent_count;
	bit                burst_mode;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic rwc_pkg::result_t judge_sequence(rwc_pkg::seq_t rx);
		rwc_pkg::result_t r;
		rwc_pkg::seq_t    gap;
		rwc_pkg::seq_t    behind;
		logic [POS_W-1:0] pos;
		r.verdict = rwc_pkg::VERDICT_OK;
		if (rx >= win_next) begin
			gap = rx - win_next;
			if (gap >= WINDOW) begin
				r.verdict = rwc_pkg::VERDICT_AHEAD;
			end else begin
				seen_bits    = seen_bits << (gap + 1);
				seen_bits[0] = 1'b1;
				win_next     = rx + 1;
			end
		end else begin
			behind = win_next - rx;
			pos    = POS_W'(behind - 1);
			if (behind > WINDOW) begin
				r.verdict = rwc_pkg::VERDICT_OLD;
			end else if (seen_bits[pos]) begin
				r.verdict = rwc_pkg::VERDICT_DUP;
			end else begin
				seen_bits[pos] = 1'b1;
			end
		end
		r.accept = (r.verdict == rwc_pkg::VERDICT_OK);
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic rwc_pkg::seq_t pick_sequence();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return win_next + $urandom_range(0, 3);
		if (r < 55)
			return win_next + $urandom_range(0, WINDOW - 1);
		if (r < 75)
			return win_next - $urandom_range(1, WINDOW);
		if (r < 82)
			return win_next - WINDOW - 1 - $urandom_range(0, 1000);
		if (r < 88)
			return win_next + WINDOW + $urandom_range(0, 1000);
		return {$urandom, $urandom};
	endfunction

	task automatic add_step(rwc_pkg::seq_t num, bit fixed, rwc_pkg::verdict_t verdict);
		plan_row_t row;
		row.num     = num;
		row.fixed   = fixed;
		row.verdict = verdict;
		plan.push_back(row);
	endtask

	task automatic send_sequence(rwc_pkg::seq_t num, bit fixed, rwc_pkg::verdict_t verdict);
		rwc_pkg::result_t predicted;
		rwc_pkg::result_t typed;
		int               gap;
		gap = idle_len();
		@(negedge clk);
		repeat (gap) begin
			seq_ch.valid <= 1'b0;
			@(negedge clk);
		end
		seq_ch.valid             <= 1'b1;
		seq_ch.received_sequence <= num;
		do @(posedge clk); while (!seq_ch.ready);
		predicted = judge_sequence(num);
		if (fixed) begin
			typed.accept  = (verdict == rwc_pkg::VERDICT_OK);
			typed.verdict = verdict;
			pending_verdicts.push_back(typed);
		end else begin
			pending_verdicts.push_back(predicted);
		end
		sent_count++;
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int  stall_left;
		int  run_left;
		bit  held;
		stall_left = 0;
		run_left   = 0;
		held       = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent_count >= 300) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
				if (run_left > 0)
					run_left--;
				else begin
					stall_left = idle_len();
					run_left   = $urandom_range(0, 12);
				end
			end
		end
	end

	always @(posedge clk) begin
		rwc_pkg::result_t want;
		if (arst_n) begin
			if ((seq_ch.valid && seq_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("replay_window_check_core verification failed");
				$finish;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					$display("%0t unexpected result: accept=%0b verdict=%0d",
						$time, res_ch.accept, res_ch.verdict);
					mismatch_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (res_ch.accept !== want.accept) begin
						$display("%0t accept mismatch: expected %0b actual %0b",
							$time, want.accept, res_ch.accept);
						mismatch_count++;
					end
					if (res_ch.verdict !== want.verdict) begin
						$display("%0t verdict mismatch: expected %0d actual %0d",
							$time, want.verdict, res_ch.verdict);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		rwc_pkg::seq_t num;
		arst_n                   = 1'b0;
		seq_ch.valid             = 1'b0;
		seq_ch.received_sequence = '0;
		res_ch.ready             = 1'b0;
		win_next                 = '0;
		seen_bits                = '0;
		mismatch_count           = 0;
		idle_cycles              = 0;
		sent_count               = 0;
		burst_mode               = 1'b0;

		add_step(64'd0, 1'b1, rwc_pkg::VERDICT_OK);
		add_step(64'd0, 1'b1, rwc_pkg::VERDICT_DUP);
		add_step(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, rwc_pkg::VERDICT_AHEAD);
		add_step(64'd64, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd1, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd1, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd0, 1'b1, rwc_pkg::VERDICT_OLD);
		add_step(64'd65, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd66, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd66, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd130, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd195, 1'b1, rwc_pkg::VERDICT_AHEAD);
		add_step(64'd67, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd66, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd130, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd100, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd100, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd194, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'h5555_5555_5555_5555, 1'b1, rwc_pkg::VERDICT_AHEAD);
		add_step(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, rwc_pkg::VERDICT_AHEAD);
		add_step(64'd194, 1'b0, rwc_pkg::VERDICT_OK);
		add_step(64'd195, 1'b0, rwc_pkg::VERDICT_OK);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			send_sequence(plan[i].num, plan[i].fixed, plan[i].verdict);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			num = pick_sequence();
			send_sequence(num, 1'b0, rwc_pkg::VERDICT_OK);
		end

		@(negedge clk);
		seq_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("replay_window_check_core verification clean");
		else
			$display("replay_window_check_core verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/rwc_pkg.sv
design/rwc_seq_if.sv
design/rwc_result_if.sv
design/rwc_eval.sv
design/replay_window_check_core.sv
verif/tb_replay_window_check_core.sv
